// File: hdl/lmld_pkg.sv
// shared types, constants and tables of the led level meter note driver
package lmld_pkg;

  localparam int NUM_SEGMENTS     = 9;
  localparam int NUM_THRESHOLDS   = 8;
  localparam int NOTE_STORE_DEPTH = 128;
  localparam int NOTE_W           = 7;
  localparam int VEL_W            = 7;
  localparam int LEVEL_W          = 16;
  localparam int SEG_W            = 4;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 7;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_A_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_B_BASE = 1'b1;

  localparam logic [NOTE_W-1:0] ROW_A_BASE_RESET = 7'd96;
  localparam logic [NOTE_W-1:0] ROW_B_BASE_RESET = 7'd112;

  typedef struct packed {
    logic [SEG_W-1:0] lit;
  } lmld_item_t;

  typedef struct packed {
    logic       vld;
    lmld_item_t item;
  } lmld_qout_t;

  function automatic logic [LEVEL_W-1:0] level_threshold(input logic [2:0] t);
    logic [LEVEL_W-1:0] th;
    case (t)
      3'd0:    th = 16'd6554;
      3'd1:    th = 16'd19661;
      3'd2:    th = 16'd29492;
      3'd3:    th = 16'd39322;
      3'd4:    th = 16'd45876;
      3'd5:    th = 16'd52429;
      3'd6:    th = 16'd58983;
      3'd7:    th = 16'd62260;
      default: th = 16'd0;
    endcase
    return th;
  endfunction

  function automatic logic [VEL_W-1:0] segment_colour(input logic [SEG_W-1:0] seg);
    logic [VEL_W-1:0] c;
    case (seg)
      4'd0:    c = 7'd32;
      4'd1:    c = 7'd48;
      4'd2:    c = 7'd49;
      4'd3:    c = 7'd50;
      4'd4:    c = 7'd51;
      4'd5:    c = 7'd35;
      4'd6:    c = 7'd19;
      4'd7:    c = 7'd3;
      4'd8:    c = 7'd1;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

  function automatic logic [SEG_W-1:0] lit_count(input logic [LEVEL_W-1:0] level);
    logic [SEG_W-1:0] n;
    n = '0;
    if (level != '0) begin
      n = SEG_W'(1);
      for (int t = 0; t < NUM_THRESHOLDS; t++) begin
        if (level >= level_threshold(3'(t))) begin
          n = n + SEG_W'(1);
        end
      end
      if (n > SEG_W'(NUM_SEGMENTS)) begin
        n = SEG_W'(NUM_SEGMENTS);
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/level_meter_led_note_driver.sv
// top level of the led bar-graph level meter note driver
//
// in_valid / in_stall carry one peak level item (unsigned Q0.16) per handshake.
// out_valid / out_stall carry note-on updates: note number, velocity and a
// last-message flag set on the final update caused by a peak. A peak that
// changes no led gives no result item.
// cfg_we writes row A base note (index 0) or row B base note (index 1).
// Each peak is classified into a lit segment count and queued (two entries);
// the note engine reads the queue, then checks 18 notes, each with a store
// read step and then a compare and write step, then flushes the held
// update; a sweep takes longer while out_stall holds the result register.
// The single port of the velocity store sets this read-then-write order.
// A changed note is held until the next changed note or the end of the sweep,
// so no result item leaves before the next changed note is compared or the
// sweep ends. While out_stall holds a valid result the engine waits on the next
// changed note, and in_stall rises once the queue is full.
// Synchronous reset clears the queue, the engine, the store's valid bits
// (all velocities read as 0) and restores base notes 96 and 112.
module level_meter_led_note_driver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lmld_pkg::LEVEL_W-1:0]    in_peak_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmld_pkg::NOTE_W-1:0]     out_note_number,
  output logic [lmld_pkg::VEL_W-1:0]      out_velocity,
  output logic                            out_last_message,
  input  logic                            cfg_we,
  input  logic [lmld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmld_pkg::CFG_DATA_W-1:0] cfg_data
);

  lmld_pkg::lmld_item_t front_item;
  lmld_pkg::lmld_qout_t qout;
  logic                 q_full;
  logic                 q_pop;

  assign in_stall = q_full;

  lmld_front u_front (
    .peak_level (in_peak_level),
    .item       (front_item)
  );

  lmld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .qout      (qout)
  );

  lmld_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .qout             (qout),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_note_number  (out_note_number),
    .out_velocity     (out_velocity),
    .out_last_message (out_last_message)
  );

endmodule

// File: hdl/lmld_front.sv
// front end: turns a peak level into a lit segment count
module lmld_front (
  input  logic [lmld_pkg::LEVEL_W-1:0] peak_level,
  output lmld_pkg::lmld_item_t         item
);

  always_comb begin
    item.lit = lmld_pkg::lit_count(peak_level);
  end

endmodule

// File: hdl/lmld_queue.sv
// two-entry item queue between the front end and the note engine
module lmld_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lmld_pkg::lmld_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output lmld_pkg::lmld_qout_t qout
);

  lmld_pkg::lmld_item_t entry_r [lmld_pkg::QUEUE_DEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == 2'(lmld_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (cnt_r != 2'd0);

  assign qout.vld  = (cnt_r != 2'd0);
  assign qout.item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/lmld_back.sv
// note engine: velocity store, per-note compare and result register
module lmld_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lmld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmld_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lmld_pkg::lmld_qout_t            qout,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmld_pkg::NOTE_W-1:0]     out_note_number,
  output logic [lmld_pkg::VEL_W-1:0]      out_velocity,
  output logic                            out_last_message
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [lmld_pkg::SEG_W-1:0]       seg_r, seg_nxt;
  logic                             row_r, row_nxt;
  logic [lmld_pkg::SEG_W-1:0]       lit_r, lit_nxt;
  logic [lmld_pkg::NOTE_W-1:0]      base_a_r, base_b_r;

  logic                             pend_vld_r, pend_vld_nxt;
  logic [lmld_pkg::NOTE_W-1:0]      pend_note_r, pend_note_nxt;
  logic [lmld_pkg::VEL_W-1:0]       pend_vel_r, pend_vel_nxt;

  logic                             out_vld_r, out_vld_nxt;
  logic [lmld_pkg::NOTE_W-1:0]      out_note_r, out_note_nxt;
  logic [lmld_pkg::VEL_W-1:0]       out_vel_r, out_vel_nxt;
  logic                             out_last_r, out_last_nxt;

  logic [lmld_pkg::VEL_W-1:0]       store_mem [lmld_pkg::NOTE_STORE_DEPTH];
  logic [lmld_pkg::NOTE_STORE_DEPTH-1:0] note_vld_r;
  logic [lmld_pkg::VEL_W-1:0]       rd_data_r;

  logic [lmld_pkg::NOTE_W-1:0]      addr;
  logic [lmld_pkg::VEL_W-1:0]       want_vel;
  logic [lmld_pkg::VEL_W-1:0]       cur_vel;
  logic                             differ;
  logic                             out_free;
  logic                             out_load;
  logic                             wr_en;
  logic                             last_check;

  assign addr = (row_r ? base_b_r : base_a_r) + lmld_pkg::NOTE_W'(seg_r);
  assign want_vel = (seg_r < lit_r) ? lmld_pkg::segment_colour(seg_r) : '0;
  assign cur_vel  = note_vld_r[addr] ? rd_data_r : '0;
  assign differ   = (cur_vel != want_vel);
  assign out_free = !out_vld_r || !out_stall;
  assign last_check = row_r && (seg_r == lmld_pkg::SEG_W'(lmld_pkg::NUM_SEGMENTS - 1));
  assign q_pop = (state_r == ST_IDLE) && qout.vld;

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    row_nxt       = row_r;
    lit_nxt       = lit_r;
    pend_vld_nxt  = pend_vld_r;
    pend_note_nxt = pend_note_r;
    pend_vel_nxt  = pend_vel_r;
    out_load      = 1'b0;
    out_note_nxt  = out_note_r;
    out_vel_nxt   = out_vel_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (qout.vld) begin
          lit_nxt   = qout.item.lit;
          seg_nxt   = '0;
          row_nxt   = 1'b0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!(differ && pend_vld_r && !out_free)) begin
          if (differ) begin
            wr_en = 1'b1;
            if (pend_vld_r) begin
              out_load     = 1'b1;
              out_note_nxt = pend_note_r;
              out_vel_nxt  = pend_vel_r;
              out_last_nxt = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_note_nxt = addr;
            pend_vel_nxt  = want_vel;
          end
          if (last_check) begin
            state_nxt = ST_FLUSH;
          end else begin
            row_nxt   = ~row_r;
            seg_nxt   = row_r ? seg_r + lmld_pkg::SEG_W'(1) : seg_r;
            state_nxt = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_note_nxt = pend_note_r;
          out_vel_nxt  = pend_vel_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_vld_nxt = out_load || (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      seg_r      <= '0;
      row_r      <= 1'b0;
      lit_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      note_vld_r <= '0;
      base_a_r   <= lmld_pkg::ROW_A_BASE_RESET;
      base_b_r   <= lmld_pkg::ROW_B_BASE_RESET;
    end else begin
      state_r    <= state_nxt;
      seg_r      <= seg_nxt;
      row_r      <= row_nxt;
      lit_r      <= lit_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (wr_en) begin
        note_vld_r[addr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          lmld_pkg::CFG_ROW_A_BASE: base_a_r <= cfg_data;
          lmld_pkg::CFG_ROW_B_BASE: base_b_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_note_r <= pend_note_nxt;
    pend_vel_r  <= pend_vel_nxt;
    out_note_r  <= out_note_nxt;
    out_vel_r   <= out_vel_nxt;
    out_last_r  <= out_last_nxt;
  end

  // single-port velocity store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[addr] <= want_vel;
    end
    rd_data_r <= store_mem[addr];
  end

  assign out_valid        = out_vld_r;
  assign out_note_number  = out_note_r;
  assign out_velocity     = out_vel_r;
  assign out_last_message = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_vld_r)
    else $error("message left pending in idle");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> note_vld_r[$past(addr)])
    else $error("written note not marked valid");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_vld_r || !out_stall))
    else $error("result register overwritten");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_READ)
    else $error("pop did not start a sweep");
`endif

endmodule
